// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the quad segment test block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define QPSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QPSC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define QPSC_ASSERT(lbl, prop, msg)
`define QPSC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/qpsc_pkg.sv
// Shared constants, register codes and control types of the quad segment test block
`timescale 1ns / 1ps
`default_nettype none

package qpsc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int NUM_CORNERS    = 4;
    localparam int CFG_ADDR_W     = 5;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_ADDR_W-3:0] {
        REG_CORNER0_X,
        REG_CORNER0_Y,
        REG_CORNER1_X,
        REG_CORNER1_Y,
        REG_CORNER2_X,
        REG_CORNER2_Y,
        REG_CORNER3_X,
        REG_CORNER3_Y
    } cfg_reg_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } qpsc_stage_ctl_t;

    typedef struct packed {
        logic start_ok;
        logic end_ok;
        logic hit;
    } qpsc_edge_flags_t;

endpackage

`default_nettype wire

// File: rtl/qpsc_if.sv
// Segment input and result output channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface qpsc_seg_if
    import qpsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid,
        output start_x,
        output start_y,
        output end_x,
        output end_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_x,
        input  start_y,
        input  end_x,
        input  end_y,
        output ready
    );
endinterface

interface qpsc_res_if;
    logic valid;
    logic ready;
    logic start_inside;
    logic end_inside;
    logic passes_through;

    modport source (
        output valid,
        output start_inside,
        output end_inside,
        output passes_through,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_inside,
        input  end_inside,
        input  passes_through,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/qpsc_cfg.sv
// APB corner registers and registered edge vectors of the quad
`timescale 1ns / 1ps
`default_nettype none

module qpsc_cfg
    import qpsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [CFG_ADDR_W-1:0]        paddr,
    input  wire logic [CFG_DATA_W-1:0]        pwdata,
    output logic      [CFG_DATA_W-1:0]        prdata,
    output logic                              pready,
    output logic signed [COORD_BITS-1:0]      corner_x [NUM_CORNERS],
    output logic signed [COORD_BITS-1:0]      corner_y [NUM_CORNERS],
    output logic signed [COORD_BITS:0]        edge_x   [NUM_CORNERS],
    output logic signed [COORD_BITS:0]        edge_y   [NUM_CORNERS]
);

    localparam int DW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] corner_x_reg  [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] corner_y_reg  [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] corner_x_next [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] corner_y_next [NUM_CORNERS];
    logic signed [DW-1:0]         edge_x_reg    [NUM_CORNERS];
    logic signed [DW-1:0]         edge_y_reg    [NUM_CORNERS];
    logic signed [DW-1:0]         edge_x_next   [NUM_CORNERS];
    logic signed [DW-1:0]         edge_y_next   [NUM_CORNERS];
    cfg_reg_t                     reg_idx;
    logic                         wr_en;
    logic signed [COORD_BITS-1:0] wr_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_val  = pwdata[COORD_BITS-1:0];

    always_comb
    begin
        corner_x_next = corner_x_reg;
        corner_y_next = corner_y_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CORNER0_X: corner_x_next[0] = wr_val;
                REG_CORNER0_Y: corner_y_next[0] = wr_val;
                REG_CORNER1_X: corner_x_next[1] = wr_val;
                REG_CORNER1_Y: corner_y_next[1] = wr_val;
                REG_CORNER2_X: corner_x_next[2] = wr_val;
                REG_CORNER2_Y: corner_y_next[2] = wr_val;
                REG_CORNER3_X: corner_x_next[3] = wr_val;
                REG_CORNER3_Y: corner_y_next[3] = wr_val;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            edge_x_next[i] = DW'(corner_x_reg[i])
                           - DW'(corner_x_reg[(i + NUM_CORNERS - 1) % NUM_CORNERS]);
            edge_y_next[i] = DW'(corner_y_reg[i])
                           - DW'(corner_y_reg[(i + NUM_CORNERS - 1) % NUM_CORNERS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                corner_x_reg[i] <= '0;
                corner_y_reg[i] <= '0;
                edge_x_reg[i]   <= '0;
                edge_y_reg[i]   <= '0;
            end
        end
        else
        begin
            corner_x_reg <= corner_x_next;
            corner_y_reg <= corner_y_next;
            edge_x_reg   <= edge_x_next;
            edge_y_reg   <= edge_y_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CORNER0_X: prdata = CFG_DATA_W'(corner_x_reg[0]);
            REG_CORNER0_Y: prdata = CFG_DATA_W'(corner_y_reg[0]);
            REG_CORNER1_X: prdata = CFG_DATA_W'(corner_x_reg[1]);
            REG_CORNER1_Y: prdata = CFG_DATA_W'(corner_y_reg[1]);
            REG_CORNER2_X: prdata = CFG_DATA_W'(corner_x_reg[2]);
            REG_CORNER2_Y: prdata = CFG_DATA_W'(corner_y_reg[2]);
            REG_CORNER3_X: prdata = CFG_DATA_W'(corner_x_reg[3]);
            REG_CORNER3_Y: prdata = CFG_DATA_W'(corner_y_reg[3]);
            default:       prdata = '0;
        endcase
    end

    assign corner_x = corner_x_reg;
    assign corner_y = corner_y_reg;
    assign edge_x   = edge_x_reg;
    assign edge_y   = edge_y_reg;

endmodule

`default_nettype wire

// File: rtl/qpsc_edge.sv
// Per-edge datapath: differences, exact products, cross sums and edge decisions
`timescale 1ns / 1ps
`default_nettype none

module qpsc_edge
    import qpsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire qpsc_stage_ctl_t         ctl,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic signed [COORD_BITS-1:0] prev_x,
    input  wire logic signed [COORD_BITS-1:0] prev_y,
    input  wire logic signed [COORD_BITS:0]   edge_x,
    input  wire logic signed [COORD_BITS:0]   edge_y,
    input  wire logic signed [COORD_BITS:0]   dsx,
    input  wire logic signed [COORD_BITS:0]   dsy,
    output qpsc_edge_flags_t                  flags
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] rx_reg, ry_reg, qx_reg, qy_reg;
    logic signed [DW-1:0] rx_next, ry_next, qx_next, qy_next;

    logic signed [PW-1:0] p_nu_a_reg, p_nu_b_reg, p_ec_a_reg, p_ec_b_reg;
    logic signed [PW-1:0] p_c_a_reg, p_c_b_reg, p_nt_a_reg, p_nt_b_reg;
    logic signed [PW-1:0] p_nu_a_next, p_nu_b_next, p_ec_a_next, p_ec_b_next;
    logic signed [PW-1:0] p_c_a_next, p_c_b_next, p_nt_a_next, p_nt_b_next;

    logic signed [SW-1:0] nu_reg, ec_reg, c_reg, nt_reg;
    logic signed [SW-1:0] nu_next, ec_next, c_next, nt_next;

    logic signed [SW:0]   nt_minus_c;
    logic                 c_pos, c_neg, nt_pos, nt_neg, nu_pos, nu_neg;
    logic                 nt_le_c, nt_ge_c, ratio_ok, u_ok;

    // r = prev - start, q = end - prev
    assign rx_next = DW'(prev_x) - DW'(start_x);
    assign ry_next = DW'(prev_y) - DW'(start_y);
    assign qx_next = DW'(end_x) - DW'(prev_x);
    assign qy_next = DW'(end_y) - DW'(prev_y);

    assign p_nu_a_next = PW'(edge_x) * PW'(ry_reg);
    assign p_nu_b_next = PW'(edge_y) * PW'(rx_reg);
    assign p_ec_a_next = PW'(edge_x) * PW'(qy_reg);
    assign p_ec_b_next = PW'(edge_y) * PW'(qx_reg);
    assign p_c_a_next  = PW'(edge_x) * PW'(dsy);
    assign p_c_b_next  = PW'(edge_y) * PW'(dsx);
    assign p_nt_a_next = PW'(ry_reg) * PW'(dsx);
    assign p_nt_b_next = PW'(rx_reg) * PW'(dsy);

    assign nu_next = SW'(p_nu_a_reg) - SW'(p_nu_b_reg);
    assign ec_next = SW'(p_ec_a_reg) - SW'(p_ec_b_reg);
    assign c_next  = SW'(p_c_a_reg)  - SW'(p_c_b_reg);
    assign nt_next = SW'(p_nt_a_reg) - SW'(p_nt_b_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
        end
        if (ctl.en2)
        begin
            p_nu_a_reg <= p_nu_a_next;
            p_nu_b_reg <= p_nu_b_next;
            p_ec_a_reg <= p_ec_a_next;
            p_ec_b_reg <= p_ec_b_next;
            p_c_a_reg  <= p_c_a_next;
            p_c_b_reg  <= p_c_b_next;
            p_nt_a_reg <= p_nt_a_next;
            p_nt_b_reg <= p_nt_b_next;
        end
        if (ctl.en3)
        begin
            nu_reg <= nu_next;
            ec_reg <= ec_next;
            c_reg  <= c_next;
            nt_reg <= nt_next;
        end
    end

    assign c_neg  = c_reg[SW-1];
    assign c_pos  = !c_reg[SW-1] && (c_reg != '0);
    assign nt_neg = nt_reg[SW-1];
    assign nt_pos = !nt_reg[SW-1] && (nt_reg != '0);
    assign nu_neg = nu_reg[SW-1];
    assign nu_pos = !nu_reg[SW-1] && (nu_reg != '0);

    // t in [0,1] as sign and magnitude checks of nt against c
    assign nt_minus_c = (SW+1)'(nt_reg) - (SW+1)'(c_reg);
    assign nt_le_c    = nt_minus_c[SW] || (nt_minus_c == '0);
    assign nt_ge_c    = !nt_minus_c[SW];

    assign ratio_ok = c_pos ? (!nt_neg && nt_le_c) : (!nt_pos && nt_ge_c);
    assign u_ok     = c_pos ? !nu_neg : !nu_pos;

    assign flags.start_ok = !nu_neg;
    assign flags.end_ok   = ec_reg[SW-1] || (ec_reg == '0);
    assign flags.hit      = (c_pos || c_neg) && ratio_ok && u_ok;

endmodule

`default_nettype wire

// File: rtl/quad_point_segment_crossing_test_core.sv
// Top level of the convex quad point and segment crossing test block
//
// Tests a segment against a convex quad held in eight corner registers and returns
// one result per segment: whether the start point is inside, whether the end point
// is inside, and whether the segment enters or crosses the quad. One segment is
// taken every clock while the result output is not stalled, and each segment passes
// through the four register stages (differences, exact products, cross sums,
// decision and output register). Back pressure stalls the stages behind a held
// result while empty stages ahead keep filling. A corner write takes effect for
// segments accepted from the cycle after the write.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quad_point_segment_crossing_test_core
    import qpsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    qpsc_seg_if.sink                    seg_in,
    qpsc_res_if.source                  res_out,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int DW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] corner_x [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] corner_y [NUM_CORNERS];
    logic signed [DW-1:0]         edge_x   [NUM_CORNERS];
    logic signed [DW-1:0]         edge_y   [NUM_CORNERS];
    qpsc_edge_flags_t             flags    [NUM_CORNERS];
    qpsc_stage_ctl_t              ctl;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic ready1, ready2, ready3, ready4;
    logic en4;

    logic signed [DW-1:0] dsx_reg, dsy_reg, dsx_next, dsy_next;

    logic start_inside_reg, end_inside_reg, passes_reg;
    logic start_inside_next, end_inside_next, passes_next;

    qpsc_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .corner_x (corner_x),
        .corner_y (corner_y),
        .edge_x   (edge_x),
        .edge_y   (edge_y)
    );

    assign ready4 = !v4_reg || res_out.ready;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign seg_in.ready = ready1;

    assign ctl.en1 = ready1 && seg_in.valid;
    assign ctl.en2 = ready2 && v1_reg;
    assign ctl.en3 = ready3 && v2_reg;
    assign en4     = ready4 && v3_reg;

    assign v1_next = ready1 ? seg_in.valid : v1_reg;
    assign v2_next = ready2 ? v1_reg       : v2_reg;
    assign v3_next = ready3 ? v2_reg       : v3_reg;
    assign v4_next = ready4 ? v3_reg       : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign dsx_next = DW'(seg_in.end_x) - DW'(seg_in.start_x);
    assign dsy_next = DW'(seg_in.end_y) - DW'(seg_in.start_y);

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            dsx_reg <= dsx_next;
            dsy_reg <= dsy_next;
        end
    end

    for (genvar i = 0; i < NUM_CORNERS; i++)
    begin : g_edge
        localparam int PREV = (i + NUM_CORNERS - 1) % NUM_CORNERS;

        qpsc_edge #(
            .COORD_BITS (COORD_BITS)
        ) u_edge (
            .clk     (clk),
            .ctl     (ctl),
            .start_x (seg_in.start_x),
            .start_y (seg_in.start_y),
            .end_x   (seg_in.end_x),
            .end_y   (seg_in.end_y),
            .prev_x  (corner_x[PREV]),
            .prev_y  (corner_y[PREV]),
            .edge_x  (edge_x[i]),
            .edge_y  (edge_y[i]),
            .dsx     (dsx_reg),
            .dsy     (dsy_reg),
            .flags   (flags[i])
        );
    end

    always_comb
    begin
        start_inside_next = 1'b1;
        end_inside_next   = 1'b1;
        passes_next       = 1'b0;
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            start_inside_next = start_inside_next && flags[i].start_ok;
            end_inside_next   = end_inside_next && flags[i].end_ok;
            passes_next       = passes_next || flags[i].hit;
        end
        passes_next = passes_next || start_inside_next || end_inside_next;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            start_inside_reg <= start_inside_next;
            end_inside_reg   <= end_inside_next;
            passes_reg       <= passes_next;
        end
    end

    assign res_out.valid          = v4_reg;
    assign res_out.start_inside   = start_inside_reg;
    assign res_out.end_inside     = end_inside_reg;
    assign res_out.passes_through = passes_reg;

    `QPSC_ASSERT(a_accept_enters_s1, seg_in.valid && seg_in.ready |=> v1_reg, "accepted beat lost at stage 1")
    `QPSC_ASSERT(a_s3_stall_holds, v3_reg && !ready3 |=> v3_reg, "stalled stage 3 beat dropped")
    `QPSC_ASSERT(a_result_from_s3, $rose(v4_reg) |-> $past(v3_reg), "result without stage 3 beat")
    `QPSC_ASSERT_NEVER(a_inside_passes, res_out.valid && (res_out.start_inside || res_out.end_inside) && !res_out.passes_through, "inside endpoint without pass")

endmodule

`default_nettype wire
